// File: design/mlr_pkg.sv
// Shared definitions for the midpoint line rasterizer.
// Item kind codes and default sizes; no dependencies.
`timescale 1ns / 1ps
package mlr_pkg;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_STEP  = 1'b1
	} func_t;

	localparam int COORD_BITS_DEF  = 12;
	localparam int QUEUE_DEPTH_DEF = 4;

endpackage

// File: design/mlr_setup.sv
// Front end of the rasterizer: accepts items and prepares line setup in two stages.
// Depends on mlr_pkg for the item kind codes.
`timescale 1ns / 1ps
module mlr_setup
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  func_t                               in_func,
	input  logic signed [COORD_BITS-1:0]        in_start_x,
	input  logic signed [COORD_BITS-1:0]        in_start_y,
	input  logic signed [COORD_BITS-1:0]        in_end_x,
	input  logic signed [COORD_BITS-1:0]        in_end_y,
	output logic                                cmd_valid,
	input  logic                                cmd_ready,
	output func_t                               cmd_func,
	output logic signed [COORD_BITS-1:0]        cmd_x0,
	output logic signed [COORD_BITS-1:0]        cmd_y0,
	output logic signed [COORD_BITS-1:0]        cmd_x1,
	output logic signed [COORD_BITS-1:0]        cmd_y1,
	output logic signed [COORD_BITS+2:0]        cmd_decision,
	output logic signed [COORD_BITS+2:0]        cmd_incr_axis,
	output logic signed [COORD_BITS+2:0]        cmd_incr_diag,
	output logic                                cmd_y_major,
	output logic                                cmd_y_down,
	output logic                                cmd_last
);

	localparam int C = COORD_BITS;
	localparam int D = COORD_BITS + 3;

	logic adv_s1, adv_s2;

	logic                valid_s1;
	func_t               func_s1;
	logic signed [C-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic        [C:0]   dx_s1, ady_s1;
	logic                y_down_s1;

	logic                valid_s2;
	func_t               func_s2;
	logic signed [C-1:0] x0_s2, y0_s2, x1_s2, y1_s2;
	logic signed [D-1:0] dec_s2, axis_s2, diag_s2;
	logic                y_major_s2, y_down_s2, last_s2;

	logic signed [C:0]   dx_fwd, dx_rev, dy_fwd, dy_rev;
	logic                swap;
	logic signed [C:0]   dy_sel, dy_neg;
	logic signed [D-1:0] dxe, adye;
	logic signed [D-1:0] dec_x, dec_y, diag_x, diag_y;
	logic                y_major;

	assign adv_s2   = !valid_s2 || cmd_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		dx_fwd = (C+1)'(in_end_x) - (C+1)'(in_start_x);
		dx_rev = (C+1)'(in_start_x) - (C+1)'(in_end_x);
		dy_fwd = (C+1)'(in_end_y) - (C+1)'(in_start_y);
		dy_rev = (C+1)'(in_start_y) - (C+1)'(in_end_y);
		swap   = dx_fwd[C];
		dy_sel = swap ? dy_rev : dy_fwd;
		dy_neg = swap ? dy_fwd : dy_rev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			func_s1   <= in_func;
			x0_s1     <= swap ? in_end_x : in_start_x;
			y0_s1     <= swap ? in_end_y : in_start_y;
			x1_s1     <= swap ? in_start_x : in_end_x;
			y1_s1     <= swap ? in_start_y : in_end_y;
			dx_s1     <= swap ? dx_rev : dx_fwd;
			y_down_s1 <= dy_sel[C];
			ady_s1    <= dy_sel[C] ? dy_neg : dy_sel;
		end
	end

	always_comb begin
		dxe     = D'(dx_s1);
		adye    = D'(ady_s1);
		y_major = ady_s1 > dx_s1;
		dec_x   = (adye <<< 1) - dxe;
		dec_y   = (dxe <<< 1) - adye;
		diag_x  = (adye - dxe) <<< 1;
		diag_y  = (dxe - adye) <<< 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			func_s2    <= func_s1;
			x0_s2      <= x0_s1;
			y0_s2      <= y0_s1;
			x1_s2      <= x1_s1;
			y1_s2      <= y1_s1;
			y_major_s2 <= y_major;
			y_down_s2  <= y_down_s1;
			dec_s2     <= y_major ? dec_y : dec_x;
			axis_s2    <= y_major ? (dxe <<< 1) : (adye <<< 1);
			diag_s2    <= y_major ? diag_y : diag_x;
			last_s2    <= y_major ? (y0_s1 == y1_s1) : (x0_s1 == x1_s1);
		end
	end

	assign cmd_valid     = valid_s2;
	assign cmd_func      = func_s2;
	assign cmd_x0        = x0_s2;
	assign cmd_y0        = y0_s2;
	assign cmd_x1        = x1_s2;
	assign cmd_y1        = y1_s2;
	assign cmd_decision  = dec_s2;
	assign cmd_incr_axis = axis_s2;
	assign cmd_incr_diag = diag_s2;
	assign cmd_y_major   = y_major_s2;
	assign cmd_y_down    = y_down_s2;
	assign cmd_last      = last_s2;

endmodule

// File: design/mlr_queue.sv
// Short command queue between the rasterizer front end and the stepper.
// Generic width and depth; uses nothing from the package.
`timescale 1ns / 1ps
module mlr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign wr_ready = count_q != CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: design/mlr_stepper.sv
// Back end of the rasterizer: holds the line state, steps it and drives the pixel output.
// Depends on mlr_pkg for the item kind codes.
`timescale 1ns / 1ps
module mlr_stepper
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  func_t                        cmd_func,
	input  logic signed [COORD_BITS-1:0] cmd_x0,
	input  logic signed [COORD_BITS-1:0] cmd_y0,
	input  logic signed [COORD_BITS-1:0] cmd_x1,
	input  logic signed [COORD_BITS-1:0] cmd_y1,
	input  logic signed [COORD_BITS+2:0] cmd_decision,
	input  logic signed [COORD_BITS+2:0] cmd_incr_axis,
	input  logic signed [COORD_BITS+2:0] cmd_incr_diag,
	input  logic                         cmd_y_major,
	input  logic                         cmd_y_down,
	input  logic                         cmd_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         out_flag,
	output logic                         out_last
);

	localparam int C = COORD_BITS;
	localparam int D = COORD_BITS + 3;

	logic signed [C-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic signed [D-1:0] decision_q, incr_axis_q, incr_diag_q;
	logic                y_major_q, y_down_q, active_q;
	logic                out_valid_q;
	logic signed [C-1:0] out_x_q, out_y_q;
	logic                out_flag_q, out_last_q;

	logic                pop;
	logic signed [C-1:0] step_y, nx, ny;
	logic signed [D-1:0] ndec;
	logic                dpos, nlast;

	assign cmd_ready = !out_valid_q || out_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_comb begin
		step_y = y_down_q ? cur_y_q - C'(1) : cur_y_q + C'(1);
		dpos   = decision_q > 0;
		if (y_major_q) begin
			ny = step_y;
			nx = dpos ? cur_x_q + C'(1) : cur_x_q;
		end else begin
			nx = cur_x_q + C'(1);
			ny = dpos ? step_y : cur_y_q;
		end
		ndec  = decision_q + (dpos ? incr_diag_q : incr_axis_q);
		nlast = y_major_q ? (ny == stop_y_q) : (nx == stop_x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			stop_x_q    <= '0;
			stop_y_q    <= '0;
			decision_q  <= '0;
			incr_axis_q <= '0;
			incr_diag_q <= '0;
			y_major_q   <= 1'b0;
			y_down_q    <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (cmd_func == FUNC_START) begin
					cur_x_q     <= cmd_x0;
					cur_y_q     <= cmd_y0;
					stop_x_q    <= cmd_x1;
					stop_y_q    <= cmd_y1;
					decision_q  <= cmd_decision;
					incr_axis_q <= cmd_incr_axis;
					incr_diag_q <= cmd_incr_diag;
					y_major_q   <= cmd_y_major;
					y_down_q    <= cmd_y_down;
					active_q    <= !cmd_last;
				end else if (active_q) begin
					cur_x_q    <= nx;
					cur_y_q    <= ny;
					decision_q <= ndec;
					active_q   <= !nlast;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cmd_func == FUNC_START) begin
				out_x_q    <= cmd_x0;
				out_y_q    <= cmd_y0;
				out_flag_q <= 1'b1;
				out_last_q <= cmd_last;
			end else if (active_q) begin
				out_x_q    <= nx;
				out_y_q    <= ny;
				out_flag_q <= 1'b1;
				out_last_q <= nlast;
			end else begin
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_flag_q <= 1'b0;
				out_last_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_flag  = out_flag_q;
	assign out_last  = out_last_q;

endmodule

// File: design/midpoint_line_rasterizer.sv
// Midpoint line rasterizer, top level: setup front end, command queue, stepper.
// An input transfer passes setup stages s1 and s2, the queue and the stepper output register.
// Throughput: one item per cycle unless m_tready stalls; stepper decision update sets it.
// Reset: arst_n clears pipeline valids, queue pointers and the line state (no line active).
// Depends on mlr_pkg, mlr_setup, mlr_queue and mlr_stepper.
`timescale 1ns / 1ps
module midpoint_line_rasterizer
	import mlr_pkg::*;
#(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// start_x, start_y, end_x, end_y
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_tdata,
	// func
	input  logic [0:0]                               s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// pixel_x, pixel_y
	output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_tdata,
	// pixel_valid
	output logic [0:0]                               m_tuser,
	output logic                                     m_tlast
);

	localparam int C  = COORD_BITS;
	localparam int D  = COORD_BITS + 3;
	localparam int OW = ((2*COORD_BITS+7)/8)*8;
	localparam int QW = 1 + 4*C + 3*D + 3;

	func_t               f_func, b_func;
	logic signed [C-1:0] f_x0, f_y0, f_x1, f_y1, b_x0, b_y0, b_x1, b_y1;
	logic signed [D-1:0] f_dec, f_axis, f_diag, b_dec, b_axis, b_diag;
	logic                f_y_major, f_y_down, f_last, b_y_major, b_y_down, b_last;
	logic                f_valid, f_ready, b_valid, b_ready;
	logic [QW-1:0]       q_in, q_out;
	logic signed [C-1:0] px, py;
	logic                pflag, plast;

	mlr_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_func      (func_t'(s_tuser[0])),
		.in_start_x   (s_tdata[C-1:0]),
		.in_start_y   (s_tdata[2*C-1:C]),
		.in_end_x     (s_tdata[3*C-1:2*C]),
		.in_end_y     (s_tdata[4*C-1:3*C]),
		.cmd_valid    (f_valid),
		.cmd_ready    (f_ready),
		.cmd_func     (f_func),
		.cmd_x0       (f_x0),
		.cmd_y0       (f_y0),
		.cmd_x1       (f_x1),
		.cmd_y1       (f_y1),
		.cmd_decision (f_dec),
		.cmd_incr_axis(f_axis),
		.cmd_incr_diag(f_diag),
		.cmd_y_major  (f_y_major),
		.cmd_y_down   (f_y_down),
		.cmd_last     (f_last)
	);

	assign q_in = {f_func, f_x0, f_y0, f_x1, f_y1, f_dec, f_axis, f_diag,
		f_y_major, f_y_down, f_last};

	mlr_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (q_in),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data (q_out)
	);

	assign b_func    = func_t'(q_out[QW-1]);
	assign b_x0      = q_out[QW-2 -: C];
	assign b_y0      = q_out[QW-2-C -: C];
	assign b_x1      = q_out[QW-2-2*C -: C];
	assign b_y1      = q_out[QW-2-3*C -: C];
	assign b_dec     = q_out[3+3*D-1 -: D];
	assign b_axis    = q_out[3+2*D-1 -: D];
	assign b_diag    = q_out[3+D-1 -: D];
	assign b_y_major = q_out[2];
	assign b_y_down  = q_out[1];
	assign b_last    = q_out[0];

	mlr_stepper #(
		.COORD_BITS(COORD_BITS)
	) u_stepper (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (b_valid),
		.cmd_ready    (b_ready),
		.cmd_func     (b_func),
		.cmd_x0       (b_x0),
		.cmd_y0       (b_y0),
		.cmd_x1       (b_x1),
		.cmd_y1       (b_y1),
		.cmd_decision (b_dec),
		.cmd_incr_axis(b_axis),
		.cmd_incr_diag(b_diag),
		.cmd_y_major  (b_y_major),
		.cmd_y_down   (b_y_down),
		.cmd_last     (b_last),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_x        (px),
		.out_y        (py),
		.out_flag     (pflag),
		.out_last     (plast)
	);

	assign m_tdata = OW'({py, px});
	assign m_tuser = pflag;
	assign m_tlast = plast;

endmodule
